// ----- design/assert_macros.svh -----
// Assertion macros shared by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ecc_pkg.sv -----
// Types, constants and calendar helpers for the epoch calendar converter.
package ecc_pkg;

	localparam int DAYS_W = 17;

	localparam logic [5:0]  SECONDS_IN_MINUTE = 6'd60;
	localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
	localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
	localparam logic [5:0]  DAYS_PER_WEEK = 6'd7;
	localparam logic [31:0] WDAY_OFFSET = 32'd4;
	localparam logic [31:0] SECONDS_IN_DAY = 32'd86400;
	localparam logic [16:0] SECONDS_IN_HOUR = 17'd3600;
	localparam logic [16:0] SECONDS_IN_MINUTE17 = 17'd60;
	localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
	localparam logic [8:0]  COMMON_YEAR_LEN = 9'd365;
	localparam logic [3:0]  LAST_MONTH = 4'd12;

	// Rounded-up reciprocals for exact division by a multiply and a shift.
	localparam logic [31:0] RECIP_60 = 32'h8888_8889; // 2^37 / 60
	localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB; // 2^36 / 24
	localparam logic [31:0] RECIP_7  = 32'h9249_2493; // 2^34 / 7

	// Position of 1970 in the 4, 100 and 400 year leap cycles.
	localparam logic [1:0] BASE_MOD4 = 2'd2;
	localparam logic [6:0] BASE_MOD100 = 7'd70;
	localparam logic [8:0] BASE_MOD400 = 9'd370;
	localparam logic [6:0] LAST_MOD100 = 7'd99;
	localparam logic [8:0] LAST_MOD400 = 9'd399;

	localparam logic OP_BREAK = 1'b0;
	localparam logic OP_MAKE = 1'b1;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [5:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [5:0]  rem;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic              make;
		logic [DAYS_W-1:0] target;
		logic [7:0]        years;
		logic [3:0]        months;
	} walk_req_t;

	typedef struct packed {
		logic              done;
		logic [DAYS_W-1:0] days;
		logic [DAYS_W-1:0] rem;
		logic [7:0]        year;
		logic [3:0]        month;
	} walk_rsp_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- design/ecc_div.sv -----
// Shared constant divider: 32-bit dividend by 60, 24 or 7 through a reciprocal multiply.
module ecc_div import ecc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        active_q;
	logic        mul_q;
	logic        done_q;
	logic [31:0] dvd_q;
	logic [5:0]  dvs_q;
	logic [63:0] prod_q;
	logic [31:0] quo_q;
	logic [5:0]  rem_q;

	logic [31:0] recip;
	logic [31:0] quot;
	logic [11:0] back;

	// The quotient is the top of the product. The remainder is below 64, so only the low
	// six bits of the dividend minus quotient times divisor are needed. Division by 7 is
	// exact for dividends below about 3.4e9, far above any day count.
	always_comb begin
		case (dvs_q)
			SECONDS_IN_MINUTE: begin
				recip = RECIP_60;
				quot  = {5'd0, prod_q[63:37]};
			end
			HOURS_PER_DAY: begin
				recip = RECIP_24;
				quot  = {4'd0, prod_q[63:36]};
			end
			default: begin
				recip = RECIP_7;
				quot  = {2'd0, prod_q[63:34]};
			end
		endcase
		back = {6'd0, quot[5:0]} * {6'd0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			mul_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			active_q <= req.start;
			mul_q    <= active_q;
			done_q   <= mul_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end
		if (active_q) prod_q <= {32'd0, dvd_q} * {32'd0, recip};
		if (mul_q) begin
			quo_q <= quot;
			rem_q <= dvd_q[5:0] - back[5:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ----- design/ecc_walk.sv -----
// Year and month walker with running Gregorian leap-cycle counters.
module ecc_walk import ecc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  walk_req_t req,
	output walk_rsp_t rsp
);

	typedef enum logic [2:0] {
		W_IDLE  = 3'b001,
		W_YEAR  = 3'b010,
		W_MONTH = 3'b100
	} walk_state_t;

	walk_state_t st_q;
	logic        done_q;
	logic        make_q;
	logic [DAYS_W-1:0] tgt_q;
	logic [DAYS_W-1:0] days_q;
	logic [DAYS_W-1:0] rem_q;
	logic [7:0]  ylim_q;
	logic [7:0]  yr_q;
	logic [3:0]  mlim_q;
	logic [3:0]  mon_q;
	logic [1:0]  m4_q;
	logic [6:0]  m100_q;
	logic [8:0]  m400_q;

	logic              leap;
	logic [8:0]        ylen;
	logic [4:0]        mlen;
	logic [DAYS_W-1:0] sum_y;
	logic              year_step;

	always_comb begin
		leap  = (m4_q == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
		ylen  = leap ? LEAP_YEAR_LEN : COMMON_YEAR_LEN;
		mlen  = month_len(mon_q, leap);
		sum_y = days_q + {{(DAYS_W-9){1'b0}}, ylen};
		year_step = make_q ? (yr_q < ylim_q) : (sum_y <= tgt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= W_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				W_IDLE: begin
					if (req.start) st_q <= W_YEAR;
				end
				W_YEAR: begin
					if (!year_step) st_q <= W_MONTH;
				end
				W_MONTH: begin
					if (make_q) begin
						if (mon_q >= mlim_q) begin
							st_q   <= W_IDLE;
							done_q <= 1'b1;
						end
					end else if ((rem_q < {{(DAYS_W-5){1'b0}}, mlen}) ||
							(mon_q == LAST_MONTH)) begin
						st_q   <= W_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			W_IDLE: begin
				if (req.start) begin
					make_q <= req.make;
					tgt_q  <= req.target;
					ylim_q <= req.years;
					mlim_q <= req.months;
					days_q <= '0;
					rem_q  <= '0;
					yr_q   <= '0;
					mon_q  <= 4'd1;
					m4_q   <= BASE_MOD4;
					m100_q <= BASE_MOD100;
					m400_q <= BASE_MOD400;
				end
			end
			W_YEAR: begin
				if (year_step) begin
					days_q <= sum_y;
					yr_q   <= yr_q + 8'd1;
					m4_q   <= m4_q + 2'd1;
					m100_q <= (m100_q == LAST_MOD100) ? 7'd0 : m100_q + 7'd1;
					m400_q <= (m400_q == LAST_MOD400) ? 9'd0 : m400_q + 9'd1;
				end else begin
					rem_q <= tgt_q - days_q;
				end
			end
			W_MONTH: begin
				if (make_q) begin
					if (mon_q < mlim_q) begin
						days_q <= days_q + {{(DAYS_W-5){1'b0}}, mlen};
						mon_q  <= mon_q + 4'd1;
					end
				end else if (rem_q >= {{(DAYS_W-5){1'b0}}, mlen}) begin
					rem_q <= rem_q - {{(DAYS_W-5){1'b0}}, mlen};
					if (mon_q != LAST_MONTH) mon_q <= mon_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.days  = days_q;
	assign rsp.rem   = rem_q;
	assign rsp.year  = yr_q;
	assign rsp.month = mon_q;

endmodule

// ----- design/epoch_calendar_converter.sv -----
// Top level of the epoch calendar converter: sequencer, divider, walker and result registers.
//
// A transaction is accepted at a rising edge where start is high and busy is low; the
// operation bit selects break mode (seconds to calendar fields) or make mode (calendar
// fields to seconds). The block then stays busy until its single result is ready.
// The result is held on the output ports, marked by done for exactly one cycle, and
// busy is low again in that same cycle, so a new start may be accepted right then.
// The receiver cannot stall: whatever is on the ports while done is high is the result.
//
// Break mode runs the shared reciprocal-multiply divider four times (by 60, 60, 24 and
// 7 for the weekday), then walks one year per cycle from 1970 and one month per cycle.
// Make mode walks in_year years and in_month - 1 months, one per cycle, with the month
// clamped to 1..12, then registers the constant multiplies and forms the final sum.
// Reset is asynchronous and active low; it returns the sequencer, divider and walker
// to idle and clears done. No transaction is in flight after reset.
`include "assert_macros.svh"

module epoch_calendar_converter import ecc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [31:0] epoch_seconds,
	input  logic [7:0]  in_year,
	input  logic [3:0]  in_month,
	input  logic [4:0]  in_day,
	input  logic [4:0]  in_hour,
	input  logic [5:0]  in_minute,
	input  logic [5:0]  in_second,
	output logic        done,
	output logic [31:0] out_seconds,
	output logic [5:0]  sec_of_minute,
	output logic [5:0]  min_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [2:0]  week_day,
	output logic [4:0]  month_day,
	output logic [3:0]  month_num,
	output logic [7:0]  year_offset
);

	// One-hot sequencer states.
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SEC  = 8'b0000_0010,
		S_MIN  = 8'b0000_0100,
		S_HOUR = 8'b0000_1000,
		S_WDAY = 8'b0001_0000,
		S_WALK = 8'b0010_0000,
		S_MUL  = 8'b0100_0000,
		S_SUM  = 8'b1000_0000
	} seq_state_t;

	seq_state_t state_q;
	logic       kick_q;
	logic       accept;

	// Captured request fields and the working value of the division chain.
	logic        op_q;
	logic [31:0] val_q;
	logic [7:0]  yr_in_q;
	logic [3:0]  mo_in_q;
	logic [4:0]  dy_in_q;
	logic [4:0]  hr_in_q;
	logic [5:0]  mi_in_q;
	logic [5:0]  se_in_q;

	// Intermediate results held between steps.
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [2:0]  wday_q;
	logic [31:0] day_secs_q;
	logic [16:0] tod_q;

	// Result registers and strobe.
	logic        done_q;
	logic [31:0] out_seconds_q;
	logic [5:0]  sec_of_minute_q;
	logic [5:0]  min_of_hour_q;
	logic [4:0]  hour_of_day_q;
	logic [2:0]  week_day_q;
	logic [4:0]  month_day_q;
	logic [3:0]  month_num_q;
	logic [7:0]  year_offset_q;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	walk_req_t walk_req;
	walk_rsp_t walk_rsp;

	logic [31:0] day_count;
	logic [16:0] tod_sum;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// The divider is loaded in the first cycle of each division state; the weekday
	// division works on the day count shifted so that day zero lands on Thursday.
	always_comb begin
		div_req.start    = kick_q && ((state_q == S_SEC) || (state_q == S_MIN) ||
			(state_q == S_HOUR) || (state_q == S_WDAY));
		div_req.dividend = val_q;
		div_req.divisor  = SECONDS_IN_MINUTE;
		case (state_q)
			S_SEC:  div_req.divisor = SECONDS_IN_MINUTE;
			S_MIN:  div_req.divisor = MINS_PER_HOUR;
			S_HOUR: div_req.divisor = HOURS_PER_DAY;
			S_WDAY: begin
				div_req.divisor  = DAYS_PER_WEEK;
				div_req.dividend = val_q + WDAY_OFFSET;
			end
			default: ;
		endcase
	end

	// In break mode the day count after three divisions is below 2^17, which
	// is the walker's target; in make mode the walker sums whole years and months.
	always_comb begin
		walk_req.start  = kick_q && (state_q == S_WALK);
		walk_req.make   = op_q;
		walk_req.target = val_q[DAYS_W-1:0];
		walk_req.years  = yr_in_q;
		walk_req.months = (mo_in_q > LAST_MONTH) ? LAST_MONTH : mo_in_q;
	end

	// Make-mode day index wraps modulo 2^32, so a day field of zero on the first
	// day of 1970 gives minus one day.
	assign day_count = {{(32-DAYS_W){1'b0}}, walk_rsp.days} + {27'd0, dy_in_q} - 32'd1;
	assign tod_sum   = {12'd0, hr_in_q} * SECONDS_IN_HOUR
		+ {11'd0, mi_in_q} * SECONDS_IN_MINUTE17 + {11'd0, se_in_q};

	ecc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ecc_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (walk_req),
		.rsp    (walk_rsp)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kick_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			kick_q <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (operation == OP_MAKE) ? S_WALK : S_SEC;
						kick_q  <= 1'b1;
					end
				end
				S_SEC: begin
					if (div_rsp.done) begin
						state_q <= S_MIN;
						kick_q  <= 1'b1;
					end
				end
				S_MIN: begin
					if (div_rsp.done) begin
						state_q <= S_HOUR;
						kick_q  <= 1'b1;
					end
				end
				S_HOUR: begin
					if (div_rsp.done) begin
						state_q <= S_WDAY;
						kick_q  <= 1'b1;
					end
				end
				S_WDAY: begin
					if (div_rsp.done) begin
						state_q <= S_WALK;
						kick_q  <= 1'b1;
					end
				end
				S_WALK: begin
					if (walk_rsp.done) begin
						if (op_q == OP_MAKE) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				S_MUL: state_q <= S_SUM;
				S_SUM: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= operation;
					val_q   <= epoch_seconds;
					yr_in_q <= in_year;
					mo_in_q <= in_month;
					dy_in_q <= in_day;
					hr_in_q <= in_hour;
					mi_in_q <= in_minute;
					se_in_q <= in_second;
				end
			end
			S_SEC: begin
				if (div_rsp.done) begin
					sec_q <= div_rsp.rem;
					val_q <= div_rsp.quot;
				end
			end
			S_MIN: begin
				if (div_rsp.done) begin
					min_q <= div_rsp.rem;
					val_q <= div_rsp.quot;
				end
			end
			S_HOUR: begin
				if (div_rsp.done) begin
					hour_q <= div_rsp.rem[4:0];
					val_q  <= div_rsp.quot;
				end
			end
			S_WDAY: begin
				if (div_rsp.done) wday_q <= div_rsp.rem[2:0] + 3'd1;
			end
			S_WALK: begin
				if (walk_rsp.done) begin
					day_secs_q <= day_count * SECONDS_IN_DAY;
					tod_q      <= tod_sum;
					if (op_q == OP_BREAK) begin
						out_seconds_q   <= '0;
						sec_of_minute_q <= sec_q;
						min_of_hour_q   <= min_q;
						hour_of_day_q   <= hour_q;
						week_day_q      <= wday_q;
						month_day_q     <= walk_rsp.rem[4:0] + 5'd1;
						month_num_q     <= walk_rsp.month;
						year_offset_q   <= walk_rsp.year;
					end
				end
			end
			S_SUM: begin
				out_seconds_q   <= day_secs_q + {15'd0, tod_q};
				sec_of_minute_q <= '0;
				min_of_hour_q   <= '0;
				hour_of_day_q   <= '0;
				week_day_q      <= '0;
				month_day_q     <= '0;
				month_num_q     <= '0;
				year_offset_q   <= '0;
			end
			default: ;
		endcase
	end

	assign done          = done_q;
	assign out_seconds   = out_seconds_q;
	assign sec_of_minute = sec_of_minute_q;
	assign min_of_hour   = min_of_hour_q;
	assign hour_of_day   = hour_of_day_q;
	assign week_day      = week_day_q;
	assign month_day     = month_day_q;
	assign month_num     = month_num_q;
	assign year_offset   = year_offset_q;

	// An accepted transaction always makes the block busy in the next cycle.
	`ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")
	// The result strobe never lasts more than one cycle.
	`ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "done held for two cycles")
	// Break results carry a weekday and a month; make results carry neither.
	`ASSERT_IMP(a_mode_fields, clk, arst_n, done, (week_day == 3'd0) == (month_num == 4'd0),
		"weekday and month disagree on mode")
	// Break results report zero seconds.
	`ASSERT_IMP(a_break_secs, clk, arst_n, done && (week_day != 3'd0), out_seconds == 32'd0,
		"break result with nonzero seconds")

endmodule
